>>> sv/ppd_pkg.sv
// Shared types and constants of the periodic pairwise distance block.
`timescale 1ns / 1ps
package ppd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_ON = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARED_OUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z       = 3'd4;

    localparam logic [30:0] BOX_RESET = 31'd65536;

    typedef struct packed {
        logic               first_atom;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  row_index;
        logic [5:0]  col_index;
        logic [63:0] distance;
        logic        row_last;
        logic        set_full;
    } t_out_item;

    typedef struct packed {
        logic        periodic_on;
        logic        squared_out;
        logic [30:0] box_x;
        logic [30:0] box_y;
        logic [30:0] box_z;
    } t_cfg;

    // Wrapped atom as it travels from front to back.
    typedef struct packed {
        logic               first_atom;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_atom;

endpackage

>>> sv/periodic_pairwise_distance.sv
// Top level of the periodic pairwise distance block.
// Usage: one atom per input word on i_in_valid / o_in_stall with i_in_item
// (first_atom restarts the set). Each atom yields one output word per
// stored earlier atom (distance, squared or floor root) and then a self word
// with row_last set; an atom arriving into a full store yields one word with
// set_full set and is dropped. Output words use o_out_valid / i_out_stall.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// The front holds each word until it is pushed, first running 32 remainder
// steps when periodic mode is on; a two-word queue lets it run ahead. The
// back works through the pairs of an atom one at a time, in root mode
// through the shared bit-serial root unit, and then emits the self word.
// Reset clears the registers to their defaults and empties the set.
// A stalled receiver holds the output register; the back then waits and
// the queue and front fill behind it before i_in_valid sees o_in_stall.
`timescale 1ns / 1ps
module periodic_pairwise_distance import ppd_pkg::*; #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    t_cfg  r_cfg;
    logic  w_q_push;
    logic  w_q_pop;
    logic  w_q_full;
    logic  w_q_empty;
    t_atom w_q_in;
    t_atom w_q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{periodic_on: 1'b0, squared_out: 1'b0, box_x: BOX_RESET,
                       box_y: BOX_RESET, box_z: BOX_RESET};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIODIC_ON: r_cfg.periodic_on <= i_cfg_data[0];
                CFG_SQUARED_OUT: r_cfg.squared_out <= i_cfg_data[0];
                CFG_BOX_X:       r_cfg.box_x       <= i_cfg_data;
                CFG_BOX_Y:       r_cfg.box_y       <= i_cfg_data;
                CFG_BOX_Z:       r_cfg.box_z       <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    ppd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_atom   (w_q_in)
    );

    ppd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    ppd_back #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_q_empty),
        .i_q_atom    (w_q_out),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> sv/ppd_front.sv
// Front end: takes input words and wraps coordinates into the box.
`timescale 1ns / 1ps
module ppd_front import ppd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_atom    o_q_atom
);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    t_fstate            r_state;
    logic               r_first;
    logic signed [31:0] r_raw [3];
    logic        [31:0] r_mag [3];
    logic        [30:0] r_rem [3];
    logic        [4:0]  r_cnt;

    logic        [30:0] w_box [3];
    logic signed [31:0] w_in  [3];
    logic        [30:0] n_rem [3];
    logic signed [31:0] w_res [3];
    logic        [31:0] w_t   [3];
    logic        [30:0] w_neg [3];

    assign w_box[0] = i_cfg.box_x;
    assign w_box[1] = i_cfg.box_y;
    assign w_box[2] = i_cfg.box_z;
    assign w_in[0]  = i_in_item.pos_x;
    assign w_in[1]  = i_in_item.pos_y;
    assign w_in[2]  = i_in_item.pos_z;

    // one restoring remainder step per axis per cycle on the magnitude
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_t[a] = {r_rem[a], r_mag[a][31]};
            if (w_t[a] >= {1'b0, w_box[a]}) begin
                n_rem[a] = 31'(w_t[a] - {1'b0, w_box[a]});
            end else begin
                n_rem[a] = w_t[a][30:0];
            end
            w_neg[a] = w_box[a] - r_rem[a];
            if (!i_cfg.periodic_on || w_box[a] == '0) begin
                w_res[a] = r_raw[a];
            end else if (r_raw[a][31] && r_rem[a] != '0) begin
                w_res[a] = {1'b0, w_neg[a]};
            end else begin
                w_res[a] = {1'b0, r_rem[a]};
            end
        end
    end

    assign o_in_stall = (r_state != F_IDLE);
    assign o_q_push   = (r_state == F_PUSH) && !i_q_full;
    assign o_q_atom   = '{first_atom: r_first, pos_x: w_res[0], pos_y: w_res[1],
                          pos_z: w_res[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_first <= i_in_item.first_atom;
                        for (int a = 0; a < 3; a++) begin
                            r_raw[a] <= w_in[a];
                            r_mag[a] <= w_in[a][31] ? 32'(-w_in[a]) : w_in[a];
                            r_rem[a] <= '0;
                        end
                        r_cnt   <= '0;
                        r_state <= i_cfg.periodic_on ? F_DIV : F_PUSH;
                    end
                end
                F_DIV: begin
                    for (int a = 0; a < 3; a++) begin
                        r_rem[a] <= n_rem[a];
                        r_mag[a] <= {r_mag[a][30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

>>> sv/ppd_fifo.sv
// Two-entry queue of wrapped atoms between front and back.
`timescale 1ns / 1ps
module ppd_fifo import ppd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_atom i_data,
    input  logic  i_pop,
    output t_atom o_data,
    output logic  o_full,
    output logic  o_empty
);

    t_atom      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> sv/ppd_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module ppd_sqrt import ppd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_radicand,
    output logic        o_done,
    output logic [32:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [65:0] r_n;
    logic [35:0] r_rem;
    logic [32:0] r_root;

    logic [35:0] w_sh;
    logic [35:0] w_trial;

    assign w_sh    = {r_rem[33:0], r_n[65:64]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign o_done  = r_done;
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // pulse after the last of the 33 steps
            r_done <= r_busy && !i_start && (r_cnt == 6'd32);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_n    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_n <= {r_n[63:0], 2'b00};
                if (w_sh >= w_trial) begin
                    r_rem  <= w_sh - w_trial;
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= w_sh;
                    r_root <= {r_root[31:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

>>> sv/ppd_back.sv
// Back end: atom store, pair distances, root and output register.
`timescale 1ns / 1ps
module ppd_back import ppd_pkg::*; #(
    parameter int MAX_ATOMS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_empty,
    input  t_atom     i_q_atom,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int CW = $clog2(MAX_ATOMS + 1);

    typedef enum logic [2:0] {B_IDLE, B_RD, B_DIFF, B_MUL, B_SUM, B_ROOT, B_EMIT} t_bstate;
    typedef enum logic [1:0] {K_PAIR, K_SELF, K_FULL} t_kind;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    t_bstate        r_state;
    t_kind          r_kind;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  r_row;
    logic [AW-1:0]  r_j;
    t_pos           r_atom;
    t_pos           r_rd;
    logic [31:0]    r_dx, r_dy, r_dz;
    logic [63:0]    r_sqx, r_sqy, r_sqz;
    logic [65:0]    r_sum;
    logic [63:0]    r_dist;
    logic           r_out_valid;
    t_out_item      r_out;
    logic           r_sq_start;

    t_pos           mem [MAX_ATOMS];

    logic [CW-1:0]  w_cnt_eff;
    logic           w_out_free;
    logic           w_we;
    logic           w_sq_done;
    logic [32:0]    w_root;
    logic [AW-1:0]  w_j_next;

    function automatic logic [31:0] f_axis_diff(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [30:0] box,
                                                input logic per);
        logic [32:0] d;
        logic [32:0] e;
        logic [31:0] m;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? 32'(33'(-d)) : d[31:0];
        // minimum image: fold back when more than half a box apart
        if (per && box != '0 && {m, 1'b0} > {2'b00, box}) begin
            e = {2'b00, box} - {1'b0, m};
            m = e[32] ? 32'(33'(-e)) : e[31:0];
        end
        return m;
    endfunction

    assign w_cnt_eff  = i_q_atom.first_atom ? '0 : r_count;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_we       = (r_state == B_EMIT) && (r_kind == K_SELF) && w_out_free;
    assign w_j_next   = AW'(r_j + 1'b1);
    assign o_q_pop    = (r_state == B_IDLE) && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_row] <= r_atom;
        end
        r_rd <= mem[r_j];
    end

    ppd_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_start),
        .i_radicand (r_sum),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_kind      <= K_PAIR;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_sq_start  <= 1'b0;
        end else begin
            r_sq_start <= (r_state == B_SUM) && !i_cfg.squared_out;
            // in B_EMIT the word register is refilled whenever it is free
            if (r_out_valid && !i_out_stall && r_state != B_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_count <= w_cnt_eff;
                        r_atom  <= '{x: i_q_atom.pos_x, y: i_q_atom.pos_y,
                                     z: i_q_atom.pos_z};
                        r_j     <= '0;
                        r_row   <= AW'(w_cnt_eff);
                        if (w_cnt_eff >= CW'(MAX_ATOMS)) begin
                            r_kind  <= K_FULL;
                            r_state <= B_EMIT;
                        end else if (w_cnt_eff == '0) begin
                            r_kind  <= K_SELF;
                            r_state <= B_EMIT;
                        end else begin
                            r_kind  <= K_PAIR;
                            r_state <= B_RD;
                        end
                    end
                end
                B_RD: r_state <= B_DIFF;
                B_DIFF: begin
                    r_dx <= f_axis_diff(r_atom.x, r_rd.x, i_cfg.box_x, i_cfg.periodic_on);
                    r_dy <= f_axis_diff(r_atom.y, r_rd.y, i_cfg.box_y, i_cfg.periodic_on);
                    r_dz <= f_axis_diff(r_atom.z, r_rd.z, i_cfg.box_z, i_cfg.periodic_on);
                    r_state <= B_MUL;
                end
                B_MUL: begin
                    r_sqx   <= r_dx * r_dx;
                    r_sqy   <= r_dy * r_dy;
                    r_sqz   <= r_dz * r_dz;
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_sum   <= 66'(r_sqx) + 66'(r_sqy) + 66'(r_sqz);
                    r_state <= B_ROOT;
                end
                B_ROOT: begin
                    if (i_cfg.squared_out) begin
                        r_dist  <= (r_sum[65:64] != 2'b00) ? '1 : r_sum[63:0];
                        r_state <= B_EMIT;
                    end else if (w_sq_done) begin
                        r_dist  <= 64'(w_root);
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        unique case (r_kind)
                            K_FULL: begin
                                r_out   <= '{row_index: '0, col_index: '0, distance: '0,
                                             row_last: 1'b0, set_full: 1'b1};
                                r_state <= B_IDLE;
                            end
                            K_SELF: begin
                                r_out   <= '{row_index: 6'(r_row), col_index: 6'(r_row),
                                             distance: '0, row_last: 1'b1, set_full: 1'b0};
                                r_count <= CW'(r_row) + CW'(1);
                                r_state <= B_IDLE;
                            end
                            K_PAIR: begin
                                r_out <= '{row_index: 6'(r_row), col_index: 6'(r_j),
                                           distance: r_dist, row_last: 1'b0,
                                           set_full: 1'b0};
                                r_j   <= w_j_next;
                                if (w_j_next == r_row) begin
                                    r_kind <= K_SELF;
                                end else begin
                                    r_state <= B_RD;
                                end
                            end
                            default: r_state <= B_IDLE;
                        endcase
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_full_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.set_full |-> r_out.distance == '0 && !r_out.row_last)
        else $error("dropped-atom word carries data");

    a_self_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.row_last |-> r_out.col_index == r_out.row_index)
        else $error("row close not on the diagonal");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ATOMS))
        else $error("atom count beyond store depth");

    a_col_below_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_RD |-> r_j < r_row)
        else $error("reading a store entry not yet written");

endmodule

>>> sim/ppd_checker.sv
// Checker for the periodic pairwise distance block: row prediction and output compare.
`timescale 1ns / 1ps
module ppd_checker import ppd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    output int                    o_pending,
    output int                    o_errors
);

    localparam int STORE_DEPTH = 64;

    logic        periodic;
    logic        squared;
    logic [30:0] box_x;
    logic [30:0] box_y;
    logic [30:0] box_z;
    int          n_atoms;
    longint      atom_x [STORE_DEPTH];
    longint      atom_y [STORE_DEPTH];
    longint      atom_z [STORE_DEPTH];
    t_out_item   expected_words [$];
    int          errors;

    assign o_pending = expected_words.size();
    assign o_errors  = errors;

    // floored modulo into [0, box), or the raw value when wrapping is off or the box is zero
    function automatic longint wrap_coord(longint v, logic [30:0] box);
        longint r;
        if (!periodic || box == 0) return v;
        r = v % longint'(box);
        if (r < 0) r += longint'(box);
        return r;
    endfunction

    function automatic longint min_image_gap(longint a, longint b, logic [30:0] box);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        if (periodic && box != 0 && 2 * d > longint'(box)) begin
            d = longint'(box) - d;
            if (d < 0) d = -d;
        end
        return d;
    endfunction

    function automatic logic [63:0] floor_root(logic [65:0] s);
        logic [33:0] r;
        logic [33:0] c;
        logic [67:0] c_sq;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            c_sq = {34'd0, c} * {34'd0, c};
            if (c_sq <= {2'b00, s}) r = c;
        end
        return {30'd0, r};
    endfunction

    task automatic predict_row(t_in_item w);
        longint      ax, ay, az;
        logic [63:0] dx, dy, dz;
        logic [65:0] sum;
        t_out_item   r;
        if (w.first_atom) n_atoms = 0;
        if (n_atoms >= STORE_DEPTH) begin
            r = '0;
            r.set_full = 1'b1;
            expected_words.push_back(r);
            return;
        end
        ax = wrap_coord(longint'(w.pos_x), box_x);
        ay = wrap_coord(longint'(w.pos_y), box_y);
        az = wrap_coord(longint'(w.pos_z), box_z);
        for (int j = 0; j < n_atoms; j++) begin
            dx = min_image_gap(ax, atom_x[j], box_x);
            dy = min_image_gap(ay, atom_y[j], box_y);
            dz = min_image_gap(az, atom_z[j], box_z);
            sum = {2'b00, dx * dx} + {2'b00, dy * dy} + {2'b00, dz * dz};
            r = '0;
            r.row_index = n_atoms[5:0];
            r.col_index = j[5:0];
            if (squared) r.distance = (sum[65:64] != 0) ? '1 : sum[63:0];
            else r.distance = floor_root(sum);
            expected_words.push_back(r);
        end
        r = '0;
        r.row_index = n_atoms[5:0];
        r.col_index = n_atoms[5:0];
        r.row_last  = 1'b1;
        expected_words.push_back(r);
        atom_x[n_atoms] = ax;
        atom_y[n_atoms] = ay;
        atom_z[n_atoms] = az;
        n_atoms++;
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            periodic <= 1'b0;
            squared  <= 1'b0;
            box_x    <= BOX_RESET;
            box_y    <= BOX_RESET;
            box_z    <= BOX_RESET;
            n_atoms  = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PERIODIC_ON: periodic <= i_cfg_data[0];
                    CFG_SQUARED_OUT: squared  <= i_cfg_data[0];
                    CFG_BOX_X:       box_x    <= i_cfg_data;
                    CFG_BOX_Y:       box_y    <= i_cfg_data;
                    CFG_BOX_Z:       box_z    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_row(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    if (errors < 10) $display("unexpected word: %p", i_out_item);
                    errors++;
                end else begin
                    e = expected_words.pop_front();
                    if (e !== i_out_item) begin
                        if (errors < 10)
                            $display("mismatch: expected %p, got %p", e, i_out_item);
                        errors++;
                    end
                end
            end
        end
    end

    initial errors = 0;

endmodule

>>> sim/periodic_pairwise_distance_tb.sv
// Testbench top for the periodic pairwise distance block: stimulus and verdict.
`timescale 1ns / 1ps
module periodic_pairwise_distance_tb;
    import ppd_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_item;
    int                    pending;
    int                    errors;
    logic                  quiet;
    int                    atoms_sent;
    int                    sets_sent;
    int                    stall_left;

    periodic_pairwise_distance u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item)
    );

    ppd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .o_pending(pending), .o_errors(errors)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (quiet) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 15) == 0) begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 9);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic send_atom(logic first, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= '{first_atom: first, pos_x: x, pos_y: y, pos_z: z};
        do @(posedge i_clk); while (in_stall);
        atoms_sent++;
        if (first) sets_sent++;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom_range(0, 32'h0003_0000);
        endcase
    endfunction

    task automatic random_sets(int n_items, bit may_continue);
        int  left;
        int  size;
        bit  first;
        left = n_items;
        first = !may_continue;
        while (left > 0) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            for (int k = 0; k < size && left > 0; k++) begin
                // occasional stray restart in the middle of a set
                send_atom((k == 0 && first) || $urandom_range(0, 30) == 0,
                          pick_coord(), pick_coord(), pick_coord());
                left--;
            end
            first = 1'b1;
            if ($urandom_range(0, 19) == 0) drain();
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = CFG_PERIODIC_ON;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_item    = '0;
        out_stall  = 1'b0;
        quiet      = 1'b0;
        stall_left = 0;
        atoms_sent = 0;
        sets_sent  = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: no wrap, root output; extreme coordinates
        send_atom(1'b1, 32'h0, 32'h0, 32'h0);
        send_atom(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_atom(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_atom(1'b0, 32'hffff_ffff, 32'h0001_0000, 32'h0000_8000);
        drain();

        // squared output, saturating sum of squares
        write_reg(CFG_SQUARED_OUT, 31'd1);
        send_atom(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_atom(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_atom(1'b0, 32'h0001_0000, 32'h0, 32'h0);
        drain();

        // wrapping: negative coordinates, half-box ties, zero box on z
        write_reg(CFG_PERIODIC_ON, 31'd1);
        write_reg(CFG_BOX_X, 31'h0003_0000);
        write_reg(CFG_BOX_Y, 31'd1);
        write_reg(CFG_BOX_Z, 31'd0);
        send_atom(1'b1, 32'hfffe_0000, 32'h8000_0000, 32'h8000_0000);
        send_atom(1'b0, 32'h0001_8000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_atom(1'b0, 32'h0002_ffff, 32'h0000_0003, 32'hffff_fffe);
        send_atom(1'b0, 32'h0003_0000, 32'hffff_ffff, 32'h0001_0000);
        drain();

        // stale store: same set continues under a new box and root output
        write_reg(CFG_SQUARED_OUT, 31'd0);
        write_reg(CFG_BOX_X, 31'h0000_1000);
        write_reg(CFG_BOX_Z, 31'h7fff_ffff);
        send_atom(1'b0, 32'h0000_0800, 32'h0, 32'h7fff_ffff);
        send_atom(1'b0, 32'hffff_f7ff, 32'h5, 32'h8000_0000);
        drain();

        // random phases under several register settings
        write_reg(CFG_BOX_X, 31'h0010_0000);
        write_reg(CFG_BOX_Y, $urandom_range(1, 31'h7fff_ffff));
        write_reg(CFG_BOX_Z, 31'h0000_8000);
        random_sets(70, 1'b1);
        // sender holds off until every row is back
        drain();

        write_reg(CFG_SQUARED_OUT, 31'd1);
        write_reg(CFG_BOX_X, 31'h7fff_ffff);
        write_reg(CFG_BOX_Y, 31'h7fff_ffff);
        write_reg(CFG_BOX_Z, 31'h7fff_ffff);
        random_sets(50, 1'b1);
        // fill the store past its depth so later atoms are dropped
        for (int k = 0; k < 68; k++)
            send_atom(k == 0, pick_coord(), pick_coord(), pick_coord());
        send_atom(1'b1, pick_coord(), pick_coord(), pick_coord());
        drain();

        write_reg(CFG_PERIODIC_ON, 31'd0);
        random_sets(60, 1'b1);
        drain();

        write_reg(CFG_PERIODIC_ON, 31'd1);
        write_reg(CFG_SQUARED_OUT, 31'd0);
        write_reg(CFG_BOX_X, 31'd1);
        write_reg(CFG_BOX_Y, 31'h0002_0000);
        write_reg(CFG_BOX_Z, $urandom_range(1, 31'h00ff_ffff));
        random_sets(40, 1'b1);
        quiet = 1'b1;
        random_sets(40, 1'b0);

        drain();
        $display("covered %0d atoms in %0d sets: root and squared output, wrap on and off,",
                 atoms_sent, sets_sent);
        $display("zero, unit and maximal boxes, stale wraps, saturation and store-full drops");
        if (errors == 0) begin
            $display("** periodic_pairwise_distance: PASSED **");
        end else begin
            $display("** periodic_pairwise_distance: FAILED **");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("timeout with %0d words outstanding", pending);
        $display("** periodic_pairwise_distance: FAILED **");
        $finish;
    end

endmodule
